// ===== src/assert_macros.svh =====
// Assertion macros shared by the pool allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== src/cflpa_pkg.sv =====
// Package with the types, constants and codes of the pool allocator.
package cflpa_pkg;

	localparam int DEF_MAX_SLOTS  = 256;
	localparam int DEF_MAX_CHUNKS = 16;

	localparam int CHUNK_W     = 5;
	localparam int CHUNK_MAX   = 16;
	localparam int CNT_W       = 4;
	localparam int BYTES_W     = 13;
	localparam int BYTES_MAX   = 4096;
	localparam int STRIDE_W    = 9;
	localparam int STRIDE_MAX  = 256;
	localparam int ROUND_MASK  = 15;
	localparam int STRIDE_SHIFT = 4;
	localparam int COUNT_W     = 9;
	localparam int COUNT_MAX   = 511;
	localparam int SLOT_OUT_W  = 8;
	localparam int OFFSET_W    = 20;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHUNK_OBJECTS = 1'b0,
		REG_OBJECT_BYTES  = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_code_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EXHAUSTED = 2'd1,
		STAT_RANGE     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_ALLOC,
		RES_EXHAUST,
		RES_FREE,
		RES_RANGE
	} res_kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_GROW,
		ST_SETTLE
	} state_t;

	typedef struct packed {
		logic      latch;
		logic      push_chunk;
		logic      push_free;
		logic      pop;
		res_kind_t result;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_free;
		logic grow;
		logic empty;
		logic free_range_err;
		logic can_grow;
		logic push_last;
	} dp_status_t;

endpackage

// ===== src/cflpa_ctrl.sv =====
// Controller state machine that sequences allocate, free and chunk growth.
`include "assert_macros.svh"

module cflpa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cflpa_pkg::dp_status_t st,
	output cflpa_pkg::ctrl_cmd_t  cmd,
	output logic                  busy
);
	import cflpa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.result = RES_NONE;
		unique case (state_q)
			ST_INIT: begin
				cmd.push_chunk = 1'b1;
				if (st.push_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				priority if (st.is_free) begin
					if (st.free_range_err) begin
						cmd.result = RES_RANGE;
					end else begin
						cmd.push_free = 1'b1;
						cmd.result = RES_FREE;
					end
				end else if (!st.empty) begin
					cmd.pop = 1'b1;
					cmd.result = RES_ALLOC;
				end else if (st.grow && st.can_grow) begin
					state_d = ST_GROW;
				end else begin
					cmd.result = RES_EXHAUST;
				end
			end
			ST_GROW: begin
				cmd.push_chunk = 1'b1;
				if (st.push_last) begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				state_d = ST_EXEC;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`ASSERT_NEXT(a_accept_exec, start && state_q == ST_IDLE, state_q == ST_EXEC, "accepted word did not reach execute")
	`ASSERT_SAME(a_grow_only_when_empty, state_q == ST_GROW, st.empty || state_q == ST_GROW && !st.is_free, "chunk growth while the list holds slots")

endmodule

// ===== src/cflpa_dp.sv =====
// Datapath with the link memory, list registers, counters and result registers.
`include "assert_macros.svh"

module cflpa_dp #(
	parameter int MAX_SLOTS  = cflpa_pkg::DEF_MAX_SLOTS,
	parameter int MAX_CHUNKS = cflpa_pkg::DEF_MAX_CHUNKS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_in,
	input  logic                              grow,
	input  logic [7:0]                        free_slot,
	input  logic                              cfg_we,
	input  logic [cflpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cflpa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  cflpa_pkg::ctrl_cmd_t              cmd,
	output cflpa_pkg::dp_status_t             st,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [cflpa_pkg::SLOT_OUT_W-1:0]  slot,
	output logic [cflpa_pkg::OFFSET_W-1:0]    object_offset,
	output logic [cflpa_pkg::COUNT_W-1:0]     free_count,
	output logic [cflpa_pkg::COUNT_W-1:0]     allocated_count
);
	import cflpa_pkg::*;

	localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int TW  = $clog2(MAX_SLOTS + 1);
	localparam int TW1 = TW + 1;
	localparam int CW  = $clog2(MAX_CHUNKS + 1);
	localparam int PW  = SW + STRIDE_W;

	logic [SW:0]           mem [MAX_SLOTS];
	logic [SW:0]           rd_q;
	logic                  we;
	logic [SW-1:0]         waddr;
	logic [SW:0]           wdata;

	logic [CHUNK_W-1:0]    chunk_n_q;
	logic [STRIDE_W-1:0]   stride_q;
	logic [SW-1:0]         head_q, head_d;
	logic                  empty_q, empty_d;
	logic [COUNT_W-1:0]    free_q, free_d;
	logic [TW-1:0]         total_q, total_d;
	logic [CW-1:0]         chunks_q, chunks_d;
	logic [CNT_W-1:0]      cnt_q;
	logic                  cmd_q;
	logic                  grow_q;
	logic [7:0]            fs_q;

	logic                  push_en;
	logic [SW-1:0]         push_idx;
	logic                  push_last;
	logic [PW-1:0]         prod;
	logic [BYTES_W:0]      bytes_rounded;

	logic                  done_q;
	status_t               status_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic [OFFSET_W-1:0]   offset_q;
	logic [COUNT_W-1:0]    free_cnt_q;
	logic [COUNT_W-1:0]    alloc_cnt_q;

	assign bytes_rounded = ({1'b0, cfg_wdata} + (BYTES_W+1)'(ROUND_MASK)) >> STRIDE_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_n_q <= CHUNK_W'(CHUNK_MAX);
			stride_q  <= STRIDE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHUNK_OBJECTS: begin
					if (cfg_wdata[CHUNK_W-1:0] == '0) begin
						chunk_n_q <= CHUNK_W'(1);
					end else if (cfg_wdata[CHUNK_W-1:0] > CHUNK_W'(CHUNK_MAX)) begin
						chunk_n_q <= CHUNK_W'(CHUNK_MAX);
					end else begin
						chunk_n_q <= cfg_wdata[CHUNK_W-1:0];
					end
				end
				REG_OBJECT_BYTES: begin
					if (cfg_wdata == '0) begin
						stride_q <= STRIDE_W'(1);
					end else if (cfg_wdata > CFG_DATA_W'(BYTES_MAX)) begin
						stride_q <= STRIDE_W'(STRIDE_MAX);
					end else begin
						stride_q <= STRIDE_W'(bytes_rounded);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign push_idx  = cmd.push_chunk ? SW'(total_q + TW'(cnt_q)) : SW'(fs_q);
	assign push_en   = cmd.push_chunk || cmd.push_free;
	assign push_last = ({1'b0, cnt_q} == (chunk_n_q - CHUNK_W'(1)));
	assign prod      = PW'(head_q) * PW'(stride_q);

	always_comb begin
		head_d   = head_q;
		empty_d  = empty_q;
		free_d   = free_q;
		total_d  = total_q;
		chunks_d = chunks_q;
		we       = 1'b0;
		waddr    = push_idx;
		wdata    = {empty_q, head_q};
		if (push_en) begin
			we      = 1'b1;
			head_d  = push_idx;
			empty_d = 1'b0;
			if (free_q != COUNT_W'(COUNT_MAX)) begin
				free_d = free_q + COUNT_W'(1);
			end
		end
		if (cmd.push_chunk && push_last) begin
			total_d  = total_q + TW'(chunk_n_q);
			chunks_d = chunks_q + CW'(1);
		end
		if (cmd.pop) begin
			if (rd_q[SW]) begin
				empty_d = 1'b1;
				head_d  = '0;
			end else begin
				head_d = rd_q[SW-1:0];
			end
			if (free_q != '0) begin
				free_d = free_q - COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			empty_q  <= 1'b1;
			free_q   <= '0;
			total_q  <= '0;
			chunks_q <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			head_q   <= head_d;
			empty_q  <= empty_d;
			free_q   <= free_d;
			total_q  <= total_d;
			chunks_q <= chunks_d;
			if (cmd.push_chunk) begin
				cnt_q <= push_last ? '0 : cnt_q + CNT_W'(1);
			end
			done_q <= (cmd.result != RES_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q  <= cmd_in;
			grow_q <= grow;
			fs_q   <= free_slot;
		end
		if (cmd.result != RES_NONE) begin
			slot_q      <= (cmd.result == RES_ALLOC) ? SLOT_OUT_W'(head_q) : '0;
			offset_q    <= (cmd.result == RES_ALLOC) ?
				OFFSET_W'({prod, STRIDE_SHIFT'(0)}) : '0;
			free_cnt_q  <= free_d;
			alloc_cnt_q <= COUNT_W'(total_d);
			unique case (cmd.result)
				RES_ALLOC:   status_q <= STAT_OK;
				RES_EXHAUST: status_q <= STAT_EXHAUSTED;
				RES_RANGE:   status_q <= STAT_RANGE;
				RES_FREE:    status_q <= STAT_OK;
				default:     status_q <= STAT_OK;
			endcase
		end
	end

	assign st.is_free        = (cmd_q == CMD_FREE);
	assign st.grow           = grow_q;
	assign st.empty          = empty_q;
	assign st.free_range_err = (32'(fs_q) >= 32'(total_q));
	assign st.can_grow       = (chunks_q < CW'(MAX_CHUNKS)) &&
		(TW1'(total_q) + TW1'(chunk_n_q) <= TW1'(MAX_SLOTS));
	assign st.push_last      = push_last;

	assign done            = done_q;
	assign status          = status_q;
	assign slot            = slot_q;
	assign object_offset   = offset_q;
	assign free_count      = free_cnt_q;
	assign allocated_count = alloc_cnt_q;

	`ASSERT_ALWAYS(a_total_bound, 32'(total_q) <= 32'(MAX_SLOTS), "slot total exceeds capacity")
	`ASSERT_SAME(a_head_in_range, !empty_q && cnt_q == '0, 32'(head_q) < 32'(total_q), "list head outside added slots")
	`ASSERT_ALWAYS(a_chunks_bound, 32'(chunks_q) <= 32'(MAX_CHUNKS), "chunk count exceeds limit")
	`ASSERT_SAME(a_pop_needs_slot, cmd.pop, !empty_q, "pop from an empty list")

endmodule

// ===== src/chunked_free_list_pool_allocator_unit.sv =====
// Top level of the chunked free-list pool allocator.
//
// After reset the block is busy while it links the first chunk, chunk_objects
// slots (16 by default), into the free list. A word is taken when start is
// high and busy is low; allocate and free then pass through an accept state and
// an execute state that does the read-modify-write of the link memory through
// its registered read port. An allocate that finds the list empty with grow set
// and room for another chunk pushes one slot of a new chunk at a time, rereads
// the new head and executes the allocate again. Each result appears on done for
// exactly one cycle and cannot be held off by the receiver.
module chunked_free_list_pool_allocator_unit #(
	parameter int MAX_SLOTS  = cflpa_pkg::DEF_MAX_SLOTS,
	parameter int MAX_CHUNKS = cflpa_pkg::DEF_MAX_CHUNKS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cmd,
	input  logic                              grow,
	input  logic [7:0]                        free_slot,
	input  logic                              cfg_we,
	input  logic [cflpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cflpa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [cflpa_pkg::SLOT_OUT_W-1:0]  slot,
	output logic [cflpa_pkg::OFFSET_W-1:0]    object_offset,
	output logic [cflpa_pkg::COUNT_W-1:0]     free_count,
	output logic [cflpa_pkg::COUNT_W-1:0]     allocated_count
);
	import cflpa_pkg::*;

	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_st;

	cflpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (dp_st),
		.cmd    (ctrl_cmd),
		.busy   (busy)
	);

	cflpa_dp #(
		.MAX_SLOTS  (MAX_SLOTS),
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_in          (cmd),
		.grow            (grow),
		.free_slot       (free_slot),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.cmd             (ctrl_cmd),
		.st              (dp_st),
		.done            (done),
		.status          (status),
		.slot            (slot),
		.object_offset   (object_offset),
		.free_count      (free_count),
		.allocated_count (allocated_count)
	);

endmodule

// ===== test/chunked_free_list_pool_allocator_unit_tb.sv =====
// Self-checking testbench for the chunked free-list pool allocator: random and directed words.
module chunked_free_list_pool_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cflpa_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int REPORT_LIMIT = 10;
	localparam int NUM_PHASES = 5;
	localparam int PHASE_LEN [NUM_PHASES] = '{80, 80, 560, 560, 60};
	localparam int PHASE_FREE_PCT [NUM_PHASES] = '{40, 40, 100, 0, 50};
	localparam int PHASE_IDLE_PCT [NUM_PHASES] = '{68, 15, 0, 68, 15};
	localparam int PHASE_CHUNK [NUM_PHASES] = '{0, 16, 31, 1, 0};
	localparam int PHASE_BYTES [NUM_PHASES] = '{1, 4096, 8191, 0, 0};

	typedef struct packed {
		cmd_code_t       op;
		logic            grow;
		logic [7:0]      slot;
	} pool_req_t;

	typedef struct packed {
		status_t                status;
		logic [SLOT_OUT_W-1:0]  slot;
		logic [OFFSET_W-1:0]    offset;
		logic [COUNT_W-1:0]     free_cnt;
		logic [COUNT_W-1:0]     total;
	} pool_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   cmd = 1'b0;
	logic                   grow = 1'b0;
	logic [7:0]             free_slot = '0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   busy;
	logic                   done;
	logic [1:0]             status;
	logic [SLOT_OUT_W-1:0]  slot;
	logic [OFFSET_W-1:0]    object_offset;
	logic [COUNT_W-1:0]     free_count;
	logic [COUNT_W-1:0]     allocated_count;

	pool_req_t     pending_words [$];
	pool_result_t  expected_results [$];
	logic [7:0]    held_slots [$];
	int            idle_pct = 0;
	int            fail_count = 0;

	logic [7:0]             link_next [DEF_MAX_SLOTS];
	bit                     link_last [DEF_MAX_SLOTS];
	logic [7:0]             list_head;
	bit                     list_empty;
	int                     chunks_added;
	int                     free_slots;
	int                     slots_total;
	logic [CHUNK_W-1:0]     cfg_chunk_objects;
	logic [BYTES_W-1:0]     cfg_object_bytes;

	chunked_free_list_pool_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.grow(grow),
		.free_slot(free_slot),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.status(status),
		.slot(slot),
		.object_offset(object_offset),
		.free_count(free_count),
		.allocated_count(allocated_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void pool_push_slot(int s);
		link_next[s] = list_head;
		link_last[s] = list_empty;
		list_head = 8'(s);
		list_empty = 1'b0;
		if (free_slots < COUNT_MAX)
			free_slots++;
	endfunction

	function automatic void pool_add_chunk();
		int n;
		n = int'(cfg_chunk_objects);
		if (n < 1)
			n = 1;
		if (n > CHUNK_MAX)
			n = CHUNK_MAX;
		if (chunks_added >= DEF_MAX_CHUNKS || slots_total + n > DEF_MAX_SLOTS)
			return;
		for (int i = 0; i < n; i++)
			pool_push_slot(slots_total + i);
		slots_total += n;
		chunks_added++;
	endfunction

	function automatic pool_result_t pool_execute(pool_req_t w);
		pool_result_t res;
		int bytes;
		res = '0;
		res.status = STAT_OK;
		if (w.op == CMD_ALLOC) begin
			if (list_empty && w.grow)
				pool_add_chunk();
			if (list_empty) begin
				res.status = STAT_EXHAUSTED;
			end else begin
				res.slot = list_head;
				if (link_last[list_head]) begin
					list_empty = 1'b1;
					list_head = '0;
				end else begin
					list_head = link_next[list_head];
				end
				if (free_slots > 0)
					free_slots--;
				bytes = int'(cfg_object_bytes);
				if (bytes < 1)
					bytes = 1;
				if (bytes > BYTES_MAX)
					bytes = BYTES_MAX;
				bytes = (bytes + ROUND_MASK) & ~ROUND_MASK;
				res.offset = OFFSET_W'(int'(res.slot) * bytes);
				held_slots.push_back(res.slot);
			end
		end else if (int'(w.slot) >= slots_total) begin
			res.status = STAT_RANGE;
		end else begin
			pool_push_slot(int'(w.slot));
		end
		res.free_cnt = COUNT_W'(free_slots);
		res.total = COUNT_W'(slots_total);
		return res;
	endfunction

	// Frees mostly return slots that are still held; only in loose mode may a free
	// hit a slot at random, which can push a slot twice.
	function automatic pool_req_t make_word(int free_pct, bit loose);
		pool_req_t w;
		int r;
		int k;
		w.op = ($urandom_range(99) < free_pct) ? CMD_FREE : CMD_ALLOC;
		w.grow = 1'($urandom_range(1));
		w.slot = 8'($urandom_range(255));
		if (w.op == CMD_FREE) begin
			r = int'($urandom_range(99));
			if (r < 80 && held_slots.size() != 0) begin
				k = int'($urandom_range(held_slots.size() - 1));
				w.slot = held_slots[k];
				held_slots.delete(k);
			end else if (loose && r < 95) begin
				w.slot = 8'($urandom_range(slots_total - 1, 0));
			end else if (slots_total < DEF_MAX_SLOTS) begin
				w.slot = 8'($urandom_range(255, slots_total));
			end else if (!loose) begin
				w.op = CMD_ALLOC;
			end
		end
		return w;
	endfunction

	task automatic push_word(cmd_code_t op, logic g, logic [7:0] s);
		pool_req_t w;
		w.op = op;
		w.grow = g;
		w.slot = s;
		pending_words.push_back(w);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_CHUNK_OBJECTS)
			cfg_chunk_objects = val[CHUNK_W-1:0];
		else
			cfg_object_bytes = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || start || busy || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic report_failure(string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", what);
	endtask

	always @(posedge clk or negedge arst_n) begin : word_driver
		pool_req_t w;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= CMD_ALLOC;
			grow <= 1'b0;
			free_slot <= '0;
		end else begin
			if (start && !busy) begin
				w.op = cmd_code_t'(cmd);
				w.grow = grow;
				w.slot = free_slot;
				expected_results.push_back(pool_execute(w));
			end
			if (!start || !busy) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
					w = pending_words.pop_front();
					start <= 1'b1;
					cmd <= w.op;
					grow <= w.grow;
					free_slot <= w.slot;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		pool_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_failure($sformatf("unexpected word: status %0d slot %0d",
					status, slot));
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || slot !== want.slot
						|| object_offset !== want.offset || free_count !== want.free_cnt
						|| allocated_count !== want.total)
					report_failure($sformatf({"mismatch (expected/actual): status %0d/%0d ",
						"slot %0d/%0d offset %0d/%0d free %0d/%0d allocated %0d/%0d"},
						want.status, status, want.slot, slot, want.offset, object_offset,
						want.free_cnt, free_count, want.total, allocated_count));
			end
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] chunk_val;
		logic [CFG_DATA_W-1:0] bytes_val;
		cfg_chunk_objects = CHUNK_W'(CHUNK_MAX);
		cfg_object_bytes = BYTES_W'(16);
		list_head = '0;
		list_empty = 1'b1;
		chunks_added = 0;
		free_slots = 0;
		slots_total = 0;
		pool_add_chunk();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Out-of-range frees, draining the first chunk, exhaustion, a push onto
		// the empty list, then growth.
		push_word(CMD_FREE, 1'b0, 8'd255);
		push_word(CMD_FREE, 1'b1, 8'd16);
		repeat (16) push_word(CMD_ALLOC, 1'b0, 8'($urandom_range(255)));
		push_word(CMD_ALLOC, 1'b0, 8'd0);
		push_word(CMD_FREE, 1'b1, 8'd0);
		push_word(CMD_ALLOC, 1'b1, 8'd255);
		push_word(CMD_ALLOC, 1'b1, 8'd0);
		push_word(CMD_FREE, 1'b0, 8'd31);
		push_word(CMD_ALLOC, 1'b0, 8'd170);
		idle_pct = 0;
		wait_idle();
		held_slots.delete();

		for (int p = 0; p < NUM_PHASES; p++) begin
			chunk_val = CFG_DATA_W'(PHASE_CHUNK[p]);
			bytes_val = CFG_DATA_W'(PHASE_BYTES[p]);
			if (p == NUM_PHASES - 1) begin
				chunk_val = CFG_DATA_W'($urandom_range(31));
				bytes_val = CFG_DATA_W'($urandom_range(8191));
			end
			write_reg(REG_CHUNK_OBJECTS, chunk_val);
			write_reg(REG_OBJECT_BYTES, bytes_val);
			idle_pct = PHASE_IDLE_PCT[p];
			for (int i = 0; i < PHASE_LEN[p]; i++) begin
				while (pending_words.size() >= 2)
					@(negedge clk);
				pending_words.push_back(make_word(PHASE_FREE_PCT[p], p >= 2));
			end
			wait_idle();
		end

		if (fail_count == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
